@@ sv/tcce_pkg.sv @@
`default_nettype none

package tcce_pkg;

  // Fixed field widths of the command and result items
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned CELL_W = 16;

  // Character codes with special meaning
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  // Reset value of the attribute register
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    OP_PUT   = 3'd0,
    OP_BACK  = 3'd1,
    OP_MOVE  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_TAB,
    ST_WRAP,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_FILL,
    ST_BS_RD,
    ST_BS_WR,
    ST_CLEAR,
    ST_DONE
  } state_e;

  // Cell address source
  typedef enum logic [2:0] {
    AS_CURSOR,
    AS_TAB,
    AS_ITEM,
    AS_PTR,
    AS_PTR_UP
  } addr_sel_e;

  // Cell write data source
  typedef enum logic [2:0] {
    WD_ZERO,
    WD_CHAR,
    WD_BLANK,
    WD_SPACE,
    WD_COPY
  } wdata_sel_e;

  // Cursor update
  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ADV,
    CUR_TAB,
    CUR_NL,
    CUR_BACK,
    CUR_MOVE,
    CUR_CLAMP
  } cur_op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load_item;
    logic       set_fail;
    logic       mem_we;
    logic       mem_re;
    addr_sel_e  asel;
    wdata_sel_e wsel;
    cur_op_e    cur_op;
    logic       ptr_clr;
    logic       ptr_inc;
    logic       tab_clr;
    logic       tab_inc;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_e  op;
    logic is_newline;
    logic is_tab;
    logic in_range;
    logic at_home;
    logic row_over;
    logic ptr_copy_end;
    logic ptr_end;
    logic tab_end;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ sv/text_console_cursor_engine_core.sv @@
`default_nettype none

// Text console cursor engine: a ROWS x COLUMNS store of 16-bit cells (character in the low
// byte, attribute in the high byte) and a cursor, driven by one command per stream
// transaction, each answered by one result transaction with status, cursor and, for a cell
// read, the cell. After reset the block sweeps the store to zero, one cell a cycle, and
// accepts no command until every cell has been written; the attribute register may be
// written meanwhile. Commands run one at a time through a controller that steps a
// single-port cell store. A tab blanks up to TAB_STEP cells, a scroll past the last row
// reads and writes each copied cell and then blanks the last row, and clear screen writes
// every cell. A new command is taken once the previous result is in the output register,
// whether or not it has been consumed yet; a result still waiting there holds the next
// command in its final step.
module text_console_cursor_engine_core #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STEP = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // char_code[7:0], col[14:8], row[19:15], zero pad
  input  wire logic [2:0]  s_axis_tuser,  // cmd[2:0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // status[0], cursor_col[7:1], cursor_row[12:8],
                                          // cell_char[20:13], cell_attr[28:21], zero pad
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  tcce_pkg::cmd_t  cmd;
  tcce_pkg::stat_t stat;

  logic [7:0]                      attr_q;
  logic                            out_status;
  logic [tcce_pkg::COL_W-1:0]      out_col;
  logic [tcce_pkg::ROW_W-1:0]      out_row;
  logic [tcce_pkg::CHAR_W-1:0]     out_char;
  logic [tcce_pkg::CHAR_W-1:0]     out_attr;

  // Write the attribute register on a completed write transaction
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcce_pkg::ATTR_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      attr_q <= pwdata[7:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {24'd0, attr_q};

  tcce_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  tcce_dp #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STEP (TAB_STEP)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .attr_i       (attr_q),
    .in_cmd_i     (s_axis_tuser),
    .in_char_i    (s_axis_tdata[7:0]),
    .in_col_i     (s_axis_tdata[14:8]),
    .in_row_i     (s_axis_tdata[19:15]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_col_o    (out_col),
    .out_row_o    (out_row),
    .out_char_o   (out_char),
    .out_attr_o   (out_attr)
  );

  // Pack the result fields
  assign m_axis_tdata = {3'd0, out_attr, out_char, out_row, out_col, out_status};

endmodule

`default_nettype wire

@@ sv/tcce_ctrl.sv @@
`default_nettype none

module tcce_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_valid_i,
  output logic                ready_o,
  input  wire tcce_pkg::stat_t stat_i,
  output tcce_pkg::cmd_t      cmd_o
);

  tcce_pkg::state_e state_q, state_d;

  // Hold the current state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcce_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Select the next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcce_pkg::ST_INIT: begin
        if (stat_i.ptr_end) state_d = tcce_pkg::ST_IDLE;
      end
      tcce_pkg::ST_IDLE: begin
        if (s_valid_i) state_d = tcce_pkg::ST_DECODE;
      end
      tcce_pkg::ST_DECODE: begin
        case (stat_i.op)
          tcce_pkg::OP_PUT: begin
            state_d = stat_i.is_tab ? tcce_pkg::ST_TAB : tcce_pkg::ST_WRAP;
          end
          tcce_pkg::OP_BACK: begin
            state_d = stat_i.at_home ? tcce_pkg::ST_DONE : tcce_pkg::ST_BS_RD;
          end
          tcce_pkg::OP_CLEAR: state_d = tcce_pkg::ST_CLEAR;
          default:            state_d = tcce_pkg::ST_DONE;
        endcase
      end
      tcce_pkg::ST_TAB: begin
        if (stat_i.tab_end) state_d = tcce_pkg::ST_WRAP;
      end
      tcce_pkg::ST_WRAP: begin
        state_d = stat_i.row_over ? tcce_pkg::ST_SCROLL_RD : tcce_pkg::ST_DONE;
      end
      tcce_pkg::ST_SCROLL_RD: state_d = tcce_pkg::ST_SCROLL_WR;
      tcce_pkg::ST_SCROLL_WR: begin
        state_d = stat_i.ptr_copy_end ? tcce_pkg::ST_FILL : tcce_pkg::ST_SCROLL_RD;
      end
      tcce_pkg::ST_FILL: begin
        if (stat_i.ptr_end) state_d = tcce_pkg::ST_DONE;
      end
      tcce_pkg::ST_BS_RD: state_d = tcce_pkg::ST_BS_WR;
      tcce_pkg::ST_BS_WR: state_d = tcce_pkg::ST_DONE;
      tcce_pkg::ST_CLEAR: begin
        if (stat_i.ptr_end) state_d = tcce_pkg::ST_DONE;
      end
      tcce_pkg::ST_DONE: begin
        if (stat_i.out_free) state_d = tcce_pkg::ST_IDLE;
      end
      default: state_d = tcce_pkg::ST_INIT;
    endcase
  end

  // Drive the datapath commands
  always_comb begin
    cmd_o   = '0;
    ready_o = 1'b0;
    case (state_q)
      tcce_pkg::ST_INIT: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.wsel    = tcce_pkg::WD_ZERO;
        cmd_o.asel    = tcce_pkg::AS_PTR;
        cmd_o.ptr_inc = 1'b1;
      end
      tcce_pkg::ST_IDLE: begin
        ready_o         = 1'b1;
        cmd_o.load_item = s_valid_i;
      end
      tcce_pkg::ST_DECODE: begin
        case (stat_i.op)
          tcce_pkg::OP_PUT: begin
            if (stat_i.is_newline) begin
              cmd_o.cur_op = tcce_pkg::CUR_NL;
            end else if (stat_i.is_tab) begin
              cmd_o.tab_clr = 1'b1;
            end else begin
              cmd_o.mem_we = 1'b1;
              cmd_o.wsel   = tcce_pkg::WD_CHAR;
              cmd_o.asel   = tcce_pkg::AS_CURSOR;
              cmd_o.cur_op = tcce_pkg::CUR_ADV;
            end
          end
          tcce_pkg::OP_BACK: begin
            if (stat_i.at_home) begin
              cmd_o.set_fail = 1'b1;
            end else begin
              cmd_o.cur_op = tcce_pkg::CUR_BACK;
            end
          end
          tcce_pkg::OP_MOVE: begin
            if (stat_i.in_range) begin
              cmd_o.cur_op = tcce_pkg::CUR_MOVE;
            end else begin
              cmd_o.set_fail = 1'b1;
            end
          end
          tcce_pkg::OP_CLEAR: cmd_o.ptr_clr = 1'b1;
          tcce_pkg::OP_READ: begin
            if (stat_i.in_range) begin
              cmd_o.mem_re = 1'b1;
              cmd_o.asel   = tcce_pkg::AS_ITEM;
            end else begin
              cmd_o.set_fail = 1'b1;
            end
          end
          default: cmd_o.set_fail = 1'b1;
        endcase
      end
      tcce_pkg::ST_TAB: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.wsel    = tcce_pkg::WD_ZERO;
        cmd_o.asel    = tcce_pkg::AS_TAB;
        cmd_o.tab_inc = 1'b1;
        if (stat_i.tab_end) cmd_o.cur_op = tcce_pkg::CUR_TAB;
      end
      tcce_pkg::ST_WRAP: begin
        cmd_o.ptr_clr = stat_i.row_over;
      end
      tcce_pkg::ST_SCROLL_RD: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.asel   = tcce_pkg::AS_PTR_UP;
      end
      tcce_pkg::ST_SCROLL_WR: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.wsel    = tcce_pkg::WD_COPY;
        cmd_o.asel    = tcce_pkg::AS_PTR;
        cmd_o.ptr_inc = 1'b1;
      end
      tcce_pkg::ST_FILL: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.wsel    = tcce_pkg::WD_ZERO;
        cmd_o.asel    = tcce_pkg::AS_PTR;
        cmd_o.ptr_inc = 1'b1;
        if (stat_i.ptr_end) cmd_o.cur_op = tcce_pkg::CUR_CLAMP;
      end
      tcce_pkg::ST_BS_RD: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.asel   = tcce_pkg::AS_CURSOR;
      end
      tcce_pkg::ST_BS_WR: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wsel   = tcce_pkg::WD_SPACE;
        cmd_o.asel   = tcce_pkg::AS_CURSOR;
      end
      tcce_pkg::ST_CLEAR: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.wsel    = tcce_pkg::WD_BLANK;
        cmd_o.asel    = tcce_pkg::AS_PTR;
        cmd_o.ptr_inc = 1'b1;
      end
      tcce_pkg::ST_DONE: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  // An accepted transaction is decoded in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && ready_o) |=> (state_q == tcce_pkg::ST_DECODE))
    else $error("accepted transaction not decoded");

  // Leave the done state only by loading the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcce_pkg::ST_DONE && state_d != tcce_pkg::ST_DONE) |-> cmd_o.out_load)
    else $error("result dropped");

  // Every scroll write follows its read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcce_pkg::ST_SCROLL_WR) |-> $past(state_q == tcce_pkg::ST_SCROLL_RD))
    else $error("scroll write without read");
`endif

endmodule

`default_nettype wire

@@ sv/tcce_dp.sv @@
`default_nettype none

module tcce_dp #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STEP = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tcce_pkg::cmd_t                cmd_i,
  output tcce_pkg::stat_t                    stat_o,
  input  wire logic [7:0]                    attr_i,
  input  wire logic [tcce_pkg::CMD_W-1:0]    in_cmd_i,
  input  wire logic [tcce_pkg::CHAR_W-1:0]   in_char_i,
  input  wire logic [tcce_pkg::COL_W-1:0]    in_col_i,
  input  wire logic [tcce_pkg::ROW_W-1:0]    in_row_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               out_status_o,
  output logic [tcce_pkg::COL_W-1:0]         out_col_o,
  output logic [tcce_pkg::ROW_W-1:0]         out_row_o,
  output logic [tcce_pkg::CHAR_W-1:0]        out_char_o,
  output logic [tcce_pkg::CHAR_W-1:0]        out_attr_o
);

  localparam int unsigned CELLS    = COLUMNS * ROWS;
  localparam int unsigned AW       = $clog2(CELLS);
  localparam int unsigned TW       = (TAB_STEP > 1) ? $clog2(TAB_STEP) : 1;
  localparam int unsigned COPY_END = COLUMNS * (ROWS - 1) - 1;
  localparam int unsigned CW       = tcce_pkg::COL_W;
  localparam int unsigned RW       = tcce_pkg::ROW_W;

  // Latched command item
  logic [tcce_pkg::CMD_W-1:0]  item_cmd_q;
  logic [tcce_pkg::CHAR_W-1:0] item_char_q;
  logic [CW-1:0]               item_col_q;
  logic [RW-1:0]               item_row_q;
  logic                        fail_q;

  // Cursor, sweep pointer and tab counter
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [AW-1:0] ptr_q;
  logic [TW-1:0] tab_q;

  // Cell store
  logic [tcce_pkg::CELL_W-1:0] cell_mem_q [CELLS];
  logic [tcce_pkg::CELL_W-1:0] rdata_q;
  logic [tcce_pkg::CELL_W-1:0] wdata;
  logic [AW-1:0]               addr;

  // Result register
  logic                        out_valid_q;
  logic                        out_status_q;
  logic [CW-1:0]               out_col_q;
  logic [RW-1:0]               out_row_q;
  logic [tcce_pkg::CELL_W-1:0] out_cell_q;

  logic [CW:0]   tab_col;
  logic [CW:0]   tab_sum;
  logic [CW:0]   col_sel;
  logic [RW-1:0] row_sel;
  logic          read_ok;

  assign tab_col = {1'b0, cur_col_q} + (CW+1)'(tab_q);
  assign tab_sum = {1'b0, cur_col_q} + (CW+1)'(TAB_STEP);

  // Report status to the controller
  always_comb begin
    stat_o.op           = tcce_pkg::op_e'(item_cmd_q);
    stat_o.is_newline   = (item_char_q == tcce_pkg::CH_NEWLINE);
    stat_o.is_tab       = (item_char_q == tcce_pkg::CH_TAB);
    stat_o.in_range     = (item_col_q < CW'(COLUMNS)) && (item_row_q < RW'(ROWS));
    stat_o.at_home      = (cur_col_q == '0) && (cur_row_q == '0);
    stat_o.row_over     = (cur_row_q > RW'(ROWS - 1));
    stat_o.ptr_copy_end = (ptr_q == AW'(COPY_END));
    stat_o.ptr_end      = (ptr_q == AW'(CELLS - 1));
    stat_o.tab_end      = (tab_q == TW'(TAB_STEP - 1)) || (tab_col == (CW+1)'(COLUMNS - 1));
    stat_o.out_free     = !out_valid_q || out_ready_i;
  end

  // Latch the accepted item and track failure
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_cmd_q  <= in_cmd_i;
      item_char_q <= in_char_i;
      item_col_q  <= in_col_i;
      item_row_q  <= in_row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_q <= 1'b0;
    end else if (cmd_i.load_item) begin
      fail_q <= 1'b0;
    end else if (cmd_i.set_fail) begin
      fail_q <= 1'b1;
    end
  end

  // Compute the next cursor position
  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    case (cmd_i.cur_op)
      tcce_pkg::CUR_ADV: begin
        if (cur_col_q == CW'(COLUMNS - 1)) begin
          cur_col_d = '0;
          cur_row_d = cur_row_q + RW'(1);
        end else begin
          cur_col_d = cur_col_q + CW'(1);
        end
      end
      tcce_pkg::CUR_TAB: begin
        if (tab_sum >= (CW+1)'(COLUMNS)) begin
          cur_col_d = '0;
          cur_row_d = cur_row_q + RW'(1);
        end else begin
          cur_col_d = tab_sum[CW-1:0];
        end
      end
      tcce_pkg::CUR_NL: begin
        cur_col_d = '0;
        cur_row_d = cur_row_q + RW'(1);
      end
      tcce_pkg::CUR_BACK: begin
        if (cur_col_q == '0) begin
          cur_col_d = CW'(COLUMNS - 1);
          cur_row_d = cur_row_q - RW'(1);
        end else begin
          cur_col_d = cur_col_q - CW'(1);
        end
      end
      tcce_pkg::CUR_MOVE: begin
        cur_col_d = item_col_q;
        cur_row_d = item_row_q;
      end
      tcce_pkg::CUR_CLAMP: cur_row_d = RW'(ROWS - 1);
      default: begin
        cur_col_d = cur_col_q;
        cur_row_d = cur_row_q;
      end
    endcase
  end

  // Hold cursor, sweep pointer and tab counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      ptr_q     <= '0;
      tab_q     <= '0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + AW'(1);
      end
      if (cmd_i.tab_clr) begin
        tab_q <= '0;
      end else if (cmd_i.tab_inc) begin
        tab_q <= tab_q + TW'(1);
      end
    end
  end

  // Select the cell address
  always_comb begin
    col_sel = {1'b0, cur_col_q};
    row_sel = cur_row_q;
    addr    = '0;
    case (cmd_i.asel)
      tcce_pkg::AS_TAB: col_sel = tab_col;
      tcce_pkg::AS_ITEM: begin
        col_sel = {1'b0, item_col_q};
        row_sel = item_row_q;
      end
      default: begin
        col_sel = {1'b0, cur_col_q};
        row_sel = cur_row_q;
      end
    endcase
    case (cmd_i.asel)
      tcce_pkg::AS_PTR:    addr = ptr_q;
      tcce_pkg::AS_PTR_UP: addr = ptr_q + AW'(COLUMNS);
      default:             addr = AW'(row_sel) * AW'(COLUMNS) + AW'(col_sel);
    endcase
  end

  // Select the cell write data
  always_comb begin
    case (cmd_i.wsel)
      tcce_pkg::WD_CHAR:  wdata = {attr_i, item_char_q};
      tcce_pkg::WD_BLANK: wdata = {attr_i, tcce_pkg::CH_SPACE};
      tcce_pkg::WD_SPACE: wdata = {rdata_q[15:8], tcce_pkg::CH_SPACE};
      tcce_pkg::WD_COPY:  wdata = rdata_q;
      default:            wdata = '0;
    endcase
  end

  // Write and read the cell store
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      cell_mem_q[addr] <= wdata;
    end
    if (cmd_i.mem_re) begin
      rdata_q <= cell_mem_q[addr];
    end
  end

  // Capture the result and hold it until taken
  assign read_ok = (item_cmd_q == tcce_pkg::OP_READ) && !fail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= fail_q;
      out_col_q    <= cur_col_q;
      out_row_q    <= cur_row_q;
      out_cell_q   <= read_ok ? rdata_q : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_col_o    = out_col_q;
  assign out_row_o    = out_row_q;
  assign out_char_o   = out_cell_q[7:0];
  assign out_attr_o   = out_cell_q[15:8];

`ifndef SYNTHESIS
  // Never overwrite a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  // Cell writes stay inside the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_we |-> (32'(addr) < 32'(CELLS)))
    else $error("cell write out of range");

  // Reported cursor is always on screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> ((cur_row_q < RW'(ROWS)) && (cur_col_q < CW'(COLUMNS))))
    else $error("cursor off screen");
`endif

endmodule

`default_nettype wire
